// File: rtl/wft_pkg.sv
// Package with the shared types, constants and helper functions of the word frequency table.
`default_nettype none
package wft_pkg;

    localparam int LEN_W            = 6;
    localparam int HASH_W           = 64;
    localparam int CNT_W            = 32;
    localparam int SLOT_OUT_W       = 8;
    localparam int CFG_IDX_W        = 2;
    localparam int DEF_TABLE_ENTRIES = 256;
    localparam int DEF_MAX_WORD_LEN  = 32;

    localparam logic [LEN_W-1:0] DEF_QUERY_MIN = 6'd3;
    localparam logic [LEN_W-1:0] DEF_QUERY_MAX = 6'd30;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_Z   = 8'h7A;
    localparam logic [7:0] CASE_DELTA = 8'h20;
    localparam logic [7:0] CH_NUL     = 8'h00;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUERY_MIN = 2'd0,
        CFG_QUERY_MAX = 2'd1
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_ADDED     = 3'd0,
        ST_COUNTED   = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_IGNORED   = 3'd4,
        ST_EMPTY     = 3'd5,
        ST_FULL      = 3'd6,
        ST_TOO_LONG  = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        S_COLLECT,
        S_EVAL,
        S_SHIFT,
        S_READ,
        S_COMPARE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       operation;
        logic [7:0] character;
        logic       last;
    } t_in_item;

    typedef struct packed {
        t_status                 status;
        logic [SLOT_OUT_W-1:0]   slot;
        logic [CNT_W-1:0]        occurrences;
        logic [CNT_W-1:0]        total_count;
        logic [HASH_W-1:0]       digest;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [LEN_W-1:0]     data;
    } t_cfg_item;

    // Control that every cell of the word row sees.
    typedef struct packed {
        logic       shift;
        logic [7:0] chr;
    } t_cell_ctl;

    // sdbm step: h * 65599 + c, modulo 2^64.
    function automatic logic [HASH_W-1:0] fold(input logic [HASH_W-1:0] h,
                                               input logic [7:0] c);
        return {56'd0, c} + (h << 6) + (h << 16) - h;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_UNDER);
    endfunction

    function automatic logic [7:0] upcase(input logic [7:0] c);
        return (c >= CH_LOW_A && c <= CH_LOW_Z) ? c - CASE_DELTA : c;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

endpackage
`default_nettype wire

// File: rtl/wft_stream_if.sv
// Valid/ready channel interface carrying one payload item.
`default_nettype none
interface wft_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/wft_cell.sv
// One byte cell of the word row: loads, shifts left and compares against a stored entry.
`default_nettype none
module wft_cell
    import wft_pkg::*;
(
    input  wire logic       i_clk,
    input  wire t_cell_ctl  i_ctl,
    input  wire logic       i_load,
    input  wire logic [7:0] i_right,
    input  wire logic       i_active,
    input  wire logic [7:0] i_ref,
    output logic [7:0]      o_byte,
    output logic            o_match
);
    logic [7:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_byte <= i_right;
        end else if (i_load) begin
            r_byte <= i_ctl.chr;
        end
    end

    // Cells past the key length do not take part in the compare.
    assign o_match = !i_active || (r_byte == i_ref);
    assign o_byte  = r_byte;
endmodule
`default_nettype wire

// File: rtl/word_frequency_table_core.sv
// Top level of the word frequency table: word collection, cell row, entry store and search.
//
//  channel   dir   payload                                          accepted when
//  i_in      in    operation, character, last                       valid & ready
//  o_out     out   status, slot, occurrences, total_count, hash     valid & ready
//  i_cfg     in    index, data (query_min/max_length)               valid & ready
//
// Characters are taken one per cycle while a word is collected. After the item
// with last set, the block decides (S_EVAL), shifts the cell row left once per
// leading blank of a query (S_SHIFT), examines each stored entry by a registered
// read of the entry store (S_READ) and then a compare (S_COMPARE), makes one more
// read that finds the end of the filled slots when nothing matches, and hands the
// result to the output register (S_DONE), waiting while that register still holds
// an unaccepted result. Input is held off from the word end until then.
// Reset is synchronous, clears counters and word state and sets the fill count to
// slot 1; the entry store needs no clearing since only slots below it are read.
`default_nettype none
module word_frequency_table_core
    import wft_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int MAX_WORD_LEN  = DEF_MAX_WORD_LEN
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    wft_stream_if.sink       i_in,
    wft_stream_if.source     o_out,
    wft_stream_if.sink       i_cfg
);
    localparam int SLOT_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int SCNT_W  = SLOT_W + 1;
    localparam int BYTES_W = MAX_WORD_LEN * 8;
    localparam logic [LEN_W-1:0]  MAX_LEN   = LEN_W'(MAX_WORD_LEN);
    localparam logic [SCNT_W-1:0] TABLE_END = SCNT_W'(TABLE_ENTRIES);

    t_state r_state, n_state;

    // Configuration registers.
    logic [LEN_W-1:0] r_qmin, r_qmax;

    // Word collection state.
    logic [LEN_W-1:0]  r_len, r_lnb, r_lead, r_shift, r_key_len;
    logic [HASH_W-1:0] r_hash, r_thash, r_hnb, r_key_hash;
    logic              r_lead_done, r_too_long, r_op;

    // Table bookkeeping.
    logic [SCNT_W-1:0] r_next_free, r_slot_idx;
    logic [CNT_W-1:0]  r_words;

    // Result being assembled, and the output register.
    t_status           r_status;
    logic [SCNT_W-1:0] r_res_slot;
    logic [CNT_W-1:0]  r_res_occ;
    logic [HASH_W-1:0] r_res_hash;
    logic              r_out_valid;
    t_out_item         r_out;

    // Entry store, one row per slot, read registered.
    logic [HASH_W-1:0]  mem_hash  [TABLE_ENTRIES];
    logic [LEN_W-1:0]   mem_len   [TABLE_ENTRIES];
    logic [CNT_W-1:0]   mem_cnt   [TABLE_ENTRIES];
    logic [BYTES_W-1:0] mem_bytes [TABLE_ENTRIES];
    logic [HASH_W-1:0]  r_rd_hash;
    logic [LEN_W-1:0]   r_rd_len;
    logic [CNT_W-1:0]   r_rd_cnt;
    logic [BYTES_W-1:0] r_rd_bytes;

    logic               w_accept, w_chr_ok, w_append, w_blank, w_out_free;
    logic [7:0]         w_chr;
    logic [HASH_W-1:0]  w_thash_new;
    logic [LEN_W-1:0]   w_tlen;
    logic               w_immediate, w_match, w_hit, w_miss, w_add_miss_ok;
    logic [MAX_WORD_LEN-1:0] w_cell_match;
    logic [BYTES_W-1:0] w_word;
    logic [CNT_W-1:0]   w_hit_cnt;
    logic               w_we_new, w_we_cnt;
    logic [SLOT_W-1:0]  w_wr_addr;
    logic [CNT_W-1:0]   w_wr_cnt;
    t_cell_ctl          w_ctl;

    assign i_in.ready  = (r_state == S_COLLECT);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign w_accept = i_in.valid && i_in.ready;
    assign w_chr    = upcase(i_in.data.character);
    // A NUL carried with the last item of an add is not part of the word.
    assign w_chr_ok = !(i_in.data.last && !i_in.data.operation && w_chr == CH_NUL);
    assign w_append = w_accept && w_chr_ok && (r_len < MAX_LEN);
    assign w_blank  = is_blank(w_chr);
    assign w_thash_new = fold(r_thash, w_chr);

    // Trimmed length of a query word.
    assign w_tlen = (r_lead_done && r_lnb > r_lead) ? r_lnb - r_lead : '0;

    always_comb begin
        if (r_too_long) begin
            w_immediate = 1'b1;
        end else if (!r_op) begin
            w_immediate = (r_len == '0);
        end else begin
            w_immediate = (r_len < r_qmin) || (r_len > r_qmax) || (w_tlen == '0);
        end
    end

    assign w_out_free = !r_out_valid || o_out.ready;

    // Word row of cells.
    assign w_ctl.shift = (r_state == S_SHIFT);
    assign w_ctl.chr   = w_chr;

    genvar k;
    generate
        for (k = 0; k < MAX_WORD_LEN; k++) begin : g_cell
            logic [7:0] w_right;
            if (k == MAX_WORD_LEN - 1) begin : g_end
                assign w_right = CH_NUL;
            end else begin : g_mid
                assign w_right = w_word[(k+1)*8 +: 8];
            end
            wft_cell u_cell (
                .i_clk    (i_clk),
                .i_ctl    (w_ctl),
                .i_load   (w_append && (r_len == LEN_W'(k))),
                .i_right  (w_right),
                .i_active (LEN_W'(k) < r_key_len),
                .i_ref    (r_rd_bytes[k*8 +: 8]),
                .o_byte   (w_word[k*8 +: 8]),
                .o_match  (w_cell_match[k])
            );
        end
    endgenerate

    assign w_match = (r_rd_hash == r_key_hash) && (r_rd_len == r_key_len) && (&w_cell_match);
    assign w_hit   = (r_state == S_COMPARE) && w_match;
    assign w_miss  = (r_state == S_READ) && (r_slot_idx >= r_next_free);
    assign w_add_miss_ok = w_miss && !r_op && (r_next_free < TABLE_END);
    assign w_hit_cnt = sat_inc(r_rd_cnt);

    assign w_we_new  = w_add_miss_ok;
    assign w_we_cnt  = w_add_miss_ok || (w_hit && !r_op);
    assign w_wr_addr = w_add_miss_ok ? r_next_free[SLOT_W-1:0] : r_slot_idx[SLOT_W-1:0];
    assign w_wr_cnt  = w_add_miss_ok ? CNT_W'(1) : w_hit_cnt;

    always_ff @(posedge i_clk) begin
        if (w_we_new) begin
            mem_hash[w_wr_addr]  <= r_key_hash;
            mem_len[w_wr_addr]   <= r_key_len;
            mem_bytes[w_wr_addr] <= w_word;
        end
        if (w_we_cnt) begin
            mem_cnt[w_wr_addr] <= w_wr_cnt;
        end
        r_rd_hash  <= mem_hash[r_slot_idx[SLOT_W-1:0]];
        r_rd_len   <= mem_len[r_slot_idx[SLOT_W-1:0]];
        r_rd_cnt   <= mem_cnt[r_slot_idx[SLOT_W-1:0]];
        r_rd_bytes <= mem_bytes[r_slot_idx[SLOT_W-1:0]];
    end

    // Sequencer: next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_COLLECT: begin
                if (w_accept && i_in.data.last) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (w_immediate) begin
                    n_state = S_DONE;
                end else if (r_op && r_lead != '0) begin
                    n_state = S_SHIFT;
                end else begin
                    n_state = S_READ;
                end
            end
            S_SHIFT: begin
                if (r_shift == LEN_W'(1)) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = w_miss ? S_DONE : S_COMPARE;
            end
            S_COMPARE: begin
                n_state = w_match ? S_DONE : S_READ;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_COLLECT;
                end
            end
            default: n_state = S_COLLECT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qmin <= DEF_QUERY_MIN;
            r_qmax <= DEF_QUERY_MAX;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.data.index)
                CFG_QUERY_MIN: r_qmin <= i_cfg.data.data;
                CFG_QUERY_MAX: r_qmax <= i_cfg.data.data;
                default: ;
            endcase
        end
    end

    // The output register fills when a result is handed off and empties when it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Word collection, search bookkeeping and result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_lnb       <= '0;
            r_lead      <= '0;
            r_hash      <= '0;
            r_thash     <= '0;
            r_hnb       <= '0;
            r_lead_done <= 1'b0;
            r_too_long  <= 1'b0;
            r_next_free <= SCNT_W'(1);
            r_words     <= '0;
        end else begin
            unique case (r_state)
                S_COLLECT: begin
                    if (w_accept) begin
                        r_op <= i_in.data.operation;
                        if (w_chr_ok && !(r_len < MAX_LEN)) begin
                            r_too_long <= 1'b1;
                        end
                        if (w_append) begin
                            r_len  <= r_len + 1'b1;
                            r_hash <= fold(r_hash, w_chr);
                            if (!r_lead_done && w_blank) begin
                                r_lead <= r_lead + 1'b1;
                            end else begin
                                r_lead_done <= 1'b1;
                                r_thash     <= w_thash_new;
                                if (!w_blank) begin
                                    r_hnb <= w_thash_new;
                                    r_lnb <= r_len + 1'b1;
                                end
                            end
                        end
                    end
                end
                S_EVAL: begin
                    r_res_slot <= '0;
                    r_res_occ  <= '0;
                    r_res_hash <= '0;
                    r_slot_idx <= SCNT_W'(1);
                    r_shift    <= r_lead;
                    if (r_too_long) begin
                        r_status <= ST_TOO_LONG;
                    end else if (!r_op) begin
                        r_status   <= ST_EMPTY;
                        r_key_hash <= r_hash;
                        r_key_len  <= r_len;
                    end else if ((r_len < r_qmin) || (r_len > r_qmax)) begin
                        r_status <= ST_IGNORED;
                    end else begin
                        // A word of blanks only trims to nothing and is never found.
                        r_status   <= ST_NOT_FOUND;
                        r_key_hash <= r_hnb;
                        r_key_len  <= w_tlen;
                    end
                end
                S_SHIFT: begin
                    r_shift <= r_shift - 1'b1;
                end
                S_READ: begin
                    if (w_miss) begin
                        r_res_hash <= r_key_hash;
                        if (r_op) begin
                            r_status <= ST_NOT_FOUND;
                        end else if (r_next_free >= TABLE_END) begin
                            r_status <= ST_FULL;
                        end else begin
                            r_status    <= ST_ADDED;
                            r_res_slot  <= r_next_free;
                            r_res_occ   <= CNT_W'(1);
                            r_next_free <= r_next_free + 1'b1;
                            r_words     <= sat_inc(r_words);
                        end
                    end
                end
                S_COMPARE: begin
                    if (w_match) begin
                        r_res_hash <= r_key_hash;
                        r_res_slot <= r_slot_idx;
                        if (r_op) begin
                            r_status  <= ST_FOUND;
                            r_res_occ <= r_rd_cnt;
                        end else begin
                            r_status  <= ST_COUNTED;
                            r_res_occ <= w_hit_cnt;
                            r_words   <= sat_inc(r_words);
                        end
                    end else begin
                        r_slot_idx <= r_slot_idx + 1'b1;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out.status      <= r_status;
                        r_out.slot        <= SLOT_OUT_W'(r_res_slot);
                        r_out.occurrences <= r_res_occ;
                        r_out.total_count <= r_words;
                        r_out.digest      <= r_res_hash;
                        r_len             <= '0;
                        r_lnb             <= '0;
                        r_lead            <= '0;
                        r_hash            <= '0;
                        r_thash           <= '0;
                        r_hnb             <= '0;
                        r_lead_done       <= 1'b0;
                        r_too_long        <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: dv/tb_word_frequency_table_core.sv
// Self-checking testbench for the word frequency table core, with its own table predictor.
`default_nettype none
module tb_word_frequency_table_core;
    import wft_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS    = DEF_TABLE_ENTRIES;
    localparam int WORD_CAP = DEF_MAX_WORD_LEN;
    // A word end may scan every slot with a read and a compare each, plus decide, shift and hand-off.
    localparam int SCAN_CYCLES = 2 * SLOTS + WORD_CAP + 16;

    typedef logic [7:0] byte_q[$];

    logic i_clk;
    logic i_rst_n;

    wft_stream_if #(.T(t_in_item))  in_ch();
    wft_stream_if #(.T(t_out_item)) out_ch();
    wft_stream_if #(.T(t_cfg_item)) cfg_ch();

    word_frequency_table_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Predictor copy of the configuration, the word being collected and the table.
    logic [LEN_W-1:0]  min_len;
    logic [LEN_W-1:0]  max_len;
    logic [7:0]        cur_bytes[WORD_CAP];
    int unsigned       cur_len;
    logic [HASH_W-1:0] full_hash;
    logic [HASH_W-1:0] trim_hash;
    logic [HASH_W-1:0] trim_hash_nb;
    int unsigned       trim_len_nb;
    int unsigned       lead_count;
    bit                past_lead;
    bit                overflow;
    logic [HASH_W-1:0] tbl_hash[SLOTS];
    int unsigned       tbl_len[SLOTS];
    logic [7:0]        tbl_bytes[SLOTS][WORD_CAP];
    logic [CNT_W-1:0]  tbl_count[SLOTS];
    int unsigned       fill_slot;
    logic [CNT_W-1:0]  word_total;

    t_out_item expected_results[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned items_sent;
    int unsigned status_hits[8];
    bit tx_gaps;
    bit rx_gaps;
    bit hold_request;

    function automatic logic [HASH_W-1:0] sdbm_step(logic [HASH_W-1:0] h, logic [7:0] c);
        return {56'd0, c} + (h << 6) + (h << 16) - h;
    endfunction

    function automatic bit blank_char(logic [7:0] c);
        return c == CH_SPACE || c == CH_UNDER;
    endfunction

    function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic byte_q from_text(string s);
        byte_q q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    task automatic clear_word();
        for (int i = 0; i < WORD_CAP; i++) cur_bytes[i] = 8'h00;
        cur_len = 0;
        full_hash = '0;
        trim_hash = '0;
        trim_hash_nb = '0;
        trim_len_nb = 0;
        lead_count = 0;
        past_lead = 1'b0;
        overflow = 1'b0;
    endtask

    // Linear search from slot 1; the bytes compared start at offset ofs of the word.
    function automatic int unsigned find_slot(logic [HASH_W-1:0] h, int unsigned ofs,
                                              int unsigned n);
        bit same;
        if (n == 0 || n > WORD_CAP) return 0;
        for (int unsigned s = 1; s < fill_slot && s < SLOTS; s++) begin
            if (tbl_len[s] == 0 || tbl_hash[s] != h || tbl_len[s] != n) continue;
            same = 1'b1;
            for (int unsigned k = 0; k < n; k++)
                if (tbl_bytes[s][k] != cur_bytes[ofs + k]) same = 1'b0;
            if (same) return s;
        end
        return 0;
    endfunction

    // Applies one accepted item to the predictor and queues a result at a word end.
    task automatic predict_item(t_in_item it);
        logic [7:0] c;
        t_out_item r;
        int unsigned s;
        int unsigned tlen;
        c = (it.character >= CH_LOW_A && it.character <= CH_LOW_Z) ?
            it.character - CASE_DELTA : it.character;
        // A trailing NUL on an add is dropped; everywhere else it is an ordinary byte.
        if (!(it.last && !it.operation && c == CH_NUL)) begin
            if (cur_len >= WORD_CAP) begin
                overflow = 1'b1;
            end else begin
                cur_bytes[cur_len] = c;
                cur_len++;
                full_hash = sdbm_step(full_hash, c);
                if (!past_lead && blank_char(c)) begin
                    lead_count++;
                end else begin
                    past_lead = 1'b1;
                    trim_hash = sdbm_step(trim_hash, c);
                    if (!blank_char(c)) begin
                        trim_hash_nb = trim_hash;
                        trim_len_nb = cur_len;
                    end
                end
            end
        end
        if (!it.last) return;
        r = '0;
        if (overflow) begin
            r.status = ST_TOO_LONG;
        end else if (!it.operation) begin
            if (cur_len == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.digest = full_hash;
                s = find_slot(full_hash, 0, cur_len);
                if (s != 0) begin
                    tbl_count[s] = bump(tbl_count[s]);
                    word_total = bump(word_total);
                    r.status = ST_COUNTED;
                    r.slot = s[7:0];
                    r.occurrences = tbl_count[s];
                end else if (fill_slot >= SLOTS) begin
                    r.status = ST_FULL;
                end else begin
                    tbl_hash[fill_slot] = full_hash;
                    tbl_len[fill_slot] = cur_len;
                    for (int k = 0; k < WORD_CAP; k++) tbl_bytes[fill_slot][k] = cur_bytes[k];
                    tbl_count[fill_slot] = 1;
                    word_total = bump(word_total);
                    r.status = ST_ADDED;
                    r.slot = fill_slot[7:0];
                    r.occurrences = 1;
                    fill_slot++;
                end
            end
        end else if (cur_len < min_len || cur_len > max_len) begin
            r.status = ST_IGNORED;
        end else begin
            // Trimmed word runs from the first to the last non-blank byte.
            tlen = (past_lead && trim_len_nb > lead_count) ? trim_len_nb - lead_count : 0;
            r.digest = (tlen != 0) ? trim_hash_nb : '0;
            s = (tlen != 0) ? find_slot(r.digest, lead_count, tlen) : 0;
            if (s != 0) begin
                r.status = ST_FOUND;
                r.slot = s[7:0];
                r.occurrences = tbl_count[s];
            end else begin
                r.status = ST_NOT_FOUND;
            end
        end
        r.total_count = word_total;
        expected_results.push_back(r);
        clear_word();
    endtask

    // Offers one item, sometimes after a random gap, and waits until it is taken.
    task automatic send_char(bit op, logic [7:0] ch, bit fin);
        t_in_item it;
        it.operation = op;
        it.character = ch;
        it.last = fin;
        if (tx_gaps && $urandom_range(99) < 32) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_item(it);
        items_sent++;
    endtask

    task automatic send_word(bit op, byte_q w);
        for (int i = 0; i < w.size(); i++) send_char(op, w[i], i == w.size() - 1);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        // Covers any search still running after the last result.
        repeat (SCAN_CYCLES) @(posedge i_clk);
    endtask

    // Writes one register; the block must be idle.
    task automatic write_reg(t_cfg_index idx, logic [LEN_W-1:0] val);
        t_cfg_item c;
        drain();
        c.index = idx;
        c.data = val;
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= c;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_QUERY_MIN) min_len = val;
        else max_len = val;
    endtask

    // Random word, mostly built from a small vocabulary so that adds and queries hit each other.
    function automatic byte_q random_word();
        string vocab[8] = '{"apple", "ring", "Stack", "zebra", "of", "queue", "tree", "hash"};
        byte_q w;
        int n;
        if ($urandom_range(99) < 20) begin
            n = $urandom_range(1, 36);
            for (int i = 0; i < n; i++) w.push_back(8'($urandom_range(255)));
            return w;
        end
        repeat ($urandom_range(3) == 0 ? $urandom_range(1, 3) : 0)
            w.push_back($urandom_range(1) ? CH_SPACE : CH_UNDER);
        w = {w, from_text(vocab[$urandom_range(7)])};
        for (int i = 0; i < w.size(); i++)
            if ($urandom_range(1) && w[i] >= 8'h41 && w[i] <= 8'h5A) w[i] = w[i] + CASE_DELTA;
        repeat ($urandom_range(3) == 0 ? $urandom_range(1, 3) : 0)
            w.push_back($urandom_range(1) ? CH_SPACE : CH_UNDER);
        if ($urandom_range(15) == 0) w.push_back(CH_NUL);
        return w;
    endfunction

    // Distinct filler word: one high byte for the first 128, two high bytes after that.
    function automatic byte_q fill_word(int n);
        byte_q w;
        if (n < 128) begin
            w = {8'h80 | 8'(n)};
        end else begin
            w = {8'h80 | 8'(n >> 4), 8'h80 | 8'(n & 15)};
        end
        return w;
    endfunction

    task automatic test_directed();
        byte_q w;
        send_word(1'b0, from_text("hello"));
        send_word(1'b0, from_text("HeLLo"));
        send_word(1'b1, from_text("hello"));
        send_word(1'b1, from_text(" _hello__"));
        send_word(1'b1, from_text("ab"));
        send_word(1'b1, from_text("nope"));
        send_word(1'b1, from_text("_ _ "));
        w = {8'h00};
        send_word(1'b0, w);
        w = {8'h41, 8'h00, 8'hFF, 8'h00};
        send_word(1'b0, w);
        send_word(1'b1, w);
        w = {8'h41, 8'h00, 8'hFF};
        send_word(1'b1, w);
        w = {};
        repeat (WORD_CAP) w.push_back(8'h7A);
        send_word(1'b0, w);
        send_word(1'b1, w);
        w.push_back(8'h80);
        send_word(1'b0, w);
        send_word(1'b1, w);
    endtask

    task automatic test_config_extremes();
        byte_q w;
        write_reg(CFG_QUERY_MIN, 6'd0);
        write_reg(CFG_QUERY_MAX, 6'd63);
        w = {8'h00};
        send_word(1'b1, w);
        send_word(1'b1, from_text("ab"));
        write_reg(CFG_QUERY_MIN, 6'd63);
        write_reg(CFG_QUERY_MAX, 6'd0);
        send_word(1'b1, from_text("hello"));
        write_reg(CFG_QUERY_MIN, 6'd5);
        write_reg(CFG_QUERY_MAX, 6'd5);
        send_word(1'b1, from_text("hello"));
        send_word(1'b1, from_text("hell"));
        send_word(1'b1, from_text("hello_"));
        write_reg(CFG_QUERY_MIN, 6'd1);
        write_reg(CFG_QUERY_MAX, 6'd32);
    endtask

    task automatic test_random(int unsigned n_items);
        int unsigned stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            // A stretch in the middle runs with no idling on either side.
            tx_gaps = !(items_sent > stop_at - n_items / 2 && items_sent < stop_at - n_items / 4);
            rx_gaps = tx_gaps;
            send_word($urandom_range(99) < 40, random_word());
        end
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    task automatic test_backpressure();
        hold_request = 1'b1;
        tx_gaps = 1'b0;
        repeat (10) send_word($urandom_range(1), random_word());
        tx_gaps = 1'b1;
    endtask

    // Adds distinct words until the table is full, then four more that find no room, then random words.
    task automatic test_full_table();
        int n;
        n = 0;
        while (fill_slot < SLOTS) begin
            send_word(1'b0, fill_word(n));
            n++;
        end
        repeat (4) begin
            send_word(1'b0, fill_word(n));
            n++;
        end
        write_reg(CFG_QUERY_MIN, 6'd3);
        write_reg(CFG_QUERY_MAX, 6'd30);
        repeat (5) send_word($urandom_range(1), random_word());
    endtask

    // Result checker with random or held-off ready.
    initial begin
        int unsigned hold_left;
        t_out_item exp_r;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %p", out_ch.data);
                end else begin
                    exp_r = expected_results.pop_front();
                    status_hits[exp_r.status]++;
                    if (out_ch.data !== exp_r) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p, got %p", exp_r, out_ch.data);
                    end
                end
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = 400;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= rx_gaps ? ($urandom_range(99) >= 32) : 1'b1;
            end
        end
    end

    initial begin
        #20ms;
        $display("tb_word_frequency_table_core failed");
        $finish;
    end

    initial begin
        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data <= '0;
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        hold_request = 1'b0;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        min_len = DEF_QUERY_MIN;
        max_len = DEF_QUERY_MAX;
        fill_slot = 1;
        word_total = '0;
        for (int s = 0; s < SLOTS; s++) begin
            tbl_len[s] = 0;
            tbl_count[s] = '0;
            tbl_hash[s] = '0;
        end
        clear_word();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_config_extremes();
        test_random(150);
        test_backpressure();
        test_full_table();
        drain();

        if (expected_results.size() != 0) mismatches += expected_results.size();
        $display("Sent %0d items, checked %0d word results over %0d table slots used.",
                 items_sent, results_seen, fill_slot - 1);
        $display("Status counts added..too long: %0d %0d %0d %0d %0d %0d %0d %0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 status_hits[4], status_hits[5], status_hits[6], status_hits[7]);
        if (mismatches == 0) begin
            $display("tb_word_frequency_table_core passed");
        end else begin
            $display("tb_word_frequency_table_core failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
